@@ hw/rtl/lre_pkg.sv @@
// ----------------------------------------------------------------------------
// lre_pkg
// Shared types and constants for the Legendre recurrence evaluator.
// ----------------------------------------------------------------------------
package lre_pkg;

    localparam int unsigned X_W    = 32;   // Q2.30 point and values
    localparam int unsigned DEG_W  = 5;    // degree / step index
    localparam int unsigned BASE_W = 12;
    localparam int unsigned SLOT_W = 13;
    localparam int unsigned XP_W   = 35;   // rounded x*P product, signed
    localparam int unsigned NUM_W  = 42;   // recurrence numerator, signed
    localparam int unsigned HI_W   = NUM_W - 32;
    localparam int unsigned Q_W    = 44;   // unsigned quotient before saturation

    localparam logic signed [X_W-1:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [X_W-1:0] NEG_ONE_Q30 = -32'sh4000_0000;
    localparam logic [X_W-1:0]        SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [X_W-1:0]        SAT_NEG     = 32'h8000_0000;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,   // latch point, degree, base
        OP_ERR,    // emit range error result
        OP_P0,     // emit P_0 = 1.0
        OP_P1,     // emit P_1 = x
        OP_MUL,    // |x| * |P_{k-1}|
        OP_NUM,    // round, build numerator
        OP_RMUL,   // low word times reciprocal
        OP_FIN     // finish quotient, emit P_k
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_of_range;
        logic at_last;
    } t_dp_status;

    function automatic logic [X_W-1:0] mag32(input logic signed [X_W-1:0] a);
        return a[X_W-1] ? X_W'(-a) : a;
    endfunction

endpackage

@@ hw/rtl/lre_ctrl.sv @@
// ----------------------------------------------------------------------------
// lre_ctrl
// Sequencer: steps the datapath through load, range check, seed values and
// the recurrence step (multiply, numerator, reciprocal multiply, finish) for each degree k >= 2.
// ----------------------------------------------------------------------------
module lre_ctrl
    import lre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_P1,
        S_MUL,
        S_NUM,
        S_RMUL,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd.op = OP_NONE;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.out_of_range) begin
                    o_cmd.op = OP_ERR;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_P0;
                    n_state  = i_status.at_last ? S_IDLE : S_P1;
                end
            end
            S_P1: begin
                o_cmd.op = OP_P1;
                n_state  = i_status.at_last ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = S_RMUL;
            end
            S_RMUL: begin
                o_cmd.op = OP_RMUL;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = i_status.at_last ? S_IDLE : S_MUL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ hw/rtl/lre_dpath.sv @@
// ----------------------------------------------------------------------------
// lre_dpath
// Recurrence datapath: operand registers, registered 32x32 multiplies for x*P and
// the reciprocal step, reciprocal table and the registered result beat.
// ----------------------------------------------------------------------------
module lre_dpath
    import lre_pkg::*;
#(
    parameter int MAX_DEGREE = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic signed [X_W-1:0]    i_x_point,
    input  logic [DEG_W-1:0]         i_degree,
    input  logic [BASE_W-1:0]        i_base_slot,
    output logic                     o_valid,
    output logic [SLOT_W-1:0]        o_slot,
    output logic signed [X_W-1:0]    o_poly_value,
    output logic                     o_range_error,
    output logic                     o_last
);

    localparam int unsigned RECIP_DEPTH = 2 ** DEG_W;

    // round(2^32 / k) in Q0.32; entries 0 and 1 unused
    logic [31:0] w_recip [RECIP_DEPTH];
    for (genvar gi = 0; gi < RECIP_DEPTH; gi++) begin : g_recip
        localparam longint unsigned DIV = (gi < 2) ? 1 : gi;
        localparam longint unsigned RV  = (gi < 2) ? 0 : (((64'd1 << 33) / DIV) + 1) >> 1;
        assign w_recip[gi] = RV[31:0];
    end

    // item registers
    logic signed [X_W-1:0]  r_x, r_pm1, r_pm2;
    logic [DEG_W-1:0]       r_n, r_k;
    logic [BASE_W-1:0]      r_base;
    // step pipeline registers
    logic [63:0]            r_prod;
    logic                   r_prod_neg;
    logic signed [NUM_W-1:0] r_num;
    logic [63:0]            r_lorc;
    logic [HI_W-1:0]        r_hi;
    logic                   r_q_neg;
    // result beat
    logic                   r_valid, r_err, r_last;
    logic [SLOT_W-1:0]      r_slot;
    logic signed [X_W-1:0]  r_value;

    logic [DEG_W-1:0]       w_n_clamped;
    logic [33:0]            w_xp_mag;
    logic signed [XP_W-1:0] w_xp;
    logic signed [7:0]      w_c1, w_c2;
    logic signed [NUM_W-1:0] w_num;
    logic [NUM_W-1:0]       w_num_mag;
    logic [31:0]            w_rc;
    logic [63:0]            w_lo_rnd;
    logic [Q_W-1:0]         w_q;
    logic signed [X_W-1:0]  w_p;
    logic [SLOT_W-1:0]      w_slot;

    assign w_n_clamped = (i_degree > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : i_degree;
    assign w_rc        = w_recip[r_k];
    assign w_slot      = {1'b0, r_base} + SLOT_W'(r_k);

    // x*P_{k-1} rounded to Q2.30, ties away from zero
    always_comb begin
        w_xp_mag = 34'((r_prod + 64'h2000_0000) >> 30);
        w_xp     = r_prod_neg ? -$signed({1'b0, w_xp_mag}) : $signed({1'b0, w_xp_mag});
        w_c1     = $signed({2'b00, r_k, 1'b0}) - 8'sd1;
        w_c2     = $signed({3'b000, r_k}) - 8'sd1;
        // operands widened first so the products keep all their bits
        w_num    = (NUM_W'(w_c1) * NUM_W'(w_xp)) - (NUM_W'(w_c2) * NUM_W'(r_pm2));
    end

    assign w_num_mag = r_num[NUM_W-1] ? NUM_W'(-r_num) : r_num;

    // quotient with rounding, then saturation to 32 bits
    always_comb begin
        w_lo_rnd = r_lorc + 64'h8000_0000;
        w_q      = (Q_W'(r_hi) * Q_W'(w_rc)) + Q_W'(w_lo_rnd[63:32]);
        if (r_q_neg) begin
            w_p = (w_q > Q_W'(SAT_NEG)) ? $signed(SAT_NEG) : $signed(-w_q[31:0]);
        end else begin
            w_p = (w_q > Q_W'(SAT_POS)) ? $signed(SAT_POS) : $signed(w_q[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_ERR) || (i_cmd.op == OP_P0) ||
                       (i_cmd.op == OP_P1) || (i_cmd.op == OP_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_x    <= i_x_point;
                r_n    <= w_n_clamped;
                r_base <= i_base_slot;
                r_k    <= '0;
            end
            OP_ERR: begin
                r_slot  <= {1'b0, r_base};
                r_value <= '0;
                r_err   <= 1'b1;
                r_last  <= 1'b1;
            end
            OP_P0: begin
                r_slot  <= w_slot;
                r_value <= ONE_Q30;
                r_err   <= 1'b0;
                r_last  <= o_status.at_last;
                r_pm1   <= ONE_Q30;
                r_pm2   <= '0;
                r_k     <= r_k + 1'b1;
            end
            OP_P1: begin
                r_slot  <= w_slot;
                r_value <= r_x;
                r_err   <= 1'b0;
                r_last  <= o_status.at_last;
                r_pm1   <= r_x;
                r_pm2   <= r_pm1;
                r_k     <= r_k + 1'b1;
            end
            OP_MUL: begin
                r_prod     <= mag32(r_x) * mag32(r_pm1);
                r_prod_neg <= r_x[X_W-1] ^ r_pm1[X_W-1];
            end
            OP_NUM: begin
                r_num <= w_num;
            end
            OP_RMUL: begin
                r_lorc  <= w_num_mag[31:0] * w_rc;
                r_hi    <= w_num_mag[NUM_W-1:32];
                r_q_neg <= r_num[NUM_W-1];
            end
            OP_FIN: begin
                r_slot  <= w_slot;
                r_value <= w_p;
                r_err   <= 1'b0;
                r_last  <= o_status.at_last;
                r_pm1   <= w_p;
                r_pm2   <= r_pm1;
                r_k     <= r_k + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_status.out_of_range = (r_x > ONE_Q30) || (r_x < NEG_ONE_Q30);
    assign o_status.at_last      = (r_k == r_n);

    assign o_valid       = r_valid;
    assign o_slot        = r_slot;
    assign o_poly_value  = r_value;
    assign o_range_error = r_err;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_err |-> r_last && (r_value == '0))
        else $error("range error beat not final or nonzero");

    a_fin_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FIN) |-> (r_k >= DEG_W'(2)))
        else $error("recurrence step issued for k below 2");

    a_k_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FIN) |=> (r_k == DEG_W'($past(r_k) + 1'b1)))
        else $error("step index did not advance");

    a_load_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |=> (r_k == '0))
        else $error("step index not cleared on load");
`endif

endmodule

@@ hw/rtl/legendre_recurrence_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// legendre_recurrence_evaluator_top
// Evaluates P_0(x)..P_n(x) by Bonnet's recurrence in Q2.30 fixed point.
// Start is taken in idle and latches the operands; the range check state then
// issues P_0 or the error beat, and P_1 follows in its own state. Each P_k for
// k >= 2 runs the dependent multiply / round / reciprocal multiply / finish
// sequence. Items do not overlap: busy stays high until the last result of an
// item has been issued. Results cannot be stalled by the receiver.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
// the result strobe; operand registers are not cleared.
// ----------------------------------------------------------------------------
module legendre_recurrence_evaluator_top
    import lre_pkg::*;
#(
    parameter int MAX_DEGREE = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command side: one beat taken when start is high and busy is low
    input  logic                  start,
    output logic                  busy,
    input  logic signed [X_W-1:0] i_x_point,
    input  logic [DEG_W-1:0]      i_degree,
    input  logic [BASE_W-1:0]     i_base_slot,
    // result side: one beat per cycle that o_valid is high
    output logic                  o_valid,
    output logic [SLOT_W-1:0]     o_slot,
    output logic signed [X_W-1:0] o_poly_value,
    output logic                  o_range_error,
    output logic                  o_last
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer: walks load, range check, seed values, then the recurrence
    // step until the step index reaches the (clamped) degree.
    lre_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath: holds x, P_{k-1}, P_{k-2}, step index and the result beat.
    // Division by k is a multiply by round(2^32/k) from a constant table.
    lre_dpath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_x_point     (i_x_point),
        .i_degree      (i_degree),
        .i_base_slot   (i_base_slot),
        .o_valid       (o_valid),
        .o_slot        (o_slot),
        .o_poly_value  (o_poly_value),
        .o_range_error (o_range_error),
        .o_last        (o_last)
    );

endmodule
